### src/isfd_pkg.sv
// shared types and constants for the imu serial frame decoder
package isfd_pkg;

    // byte codes on the serial link
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // frame layout: header, type, then payload bytes 2..7
    localparam logic [3:0] BODY_START = 4'd2;
    localparam logic [3:0] LAST_DATA  = 4'd7;
    localparam int         NUM_DATA   = 6;
    localparam int         NUM_AXES   = 3;

    localparam int RAW_W   = 16;
    localparam int VALUE_W = 29;
    localparam int OFFS_W  = 28;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_BIAS_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_BIAS_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_BIAS_Z = 2'd2;

    // scale factors for Q16 output
    localparam logic signed [VALUE_W-1:0] ACC_GAIN   = 29'sd32;
    localparam logic signed [VALUE_W-1:0] RATE_GAIN  = 29'sd4000;
    localparam logic signed [VALUE_W-1:0] ANGLE_GAIN = 29'sd360;
    localparam logic signed [VALUE_W-1:0] ANGLE_BIAS = 29'sd5898240;

    typedef enum logic [1:0] {
        PHASE_HUNT = 2'd0,
        PHASE_HDR  = 2'd1,
        PHASE_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    // one completed frame handed from the parser to the scaler
    typedef struct packed {
        kind_t                        kind;
        logic [NUM_AXES-1:0][RAW_W-1:0] raw;
    } frame_t;

endpackage

### src/isfd_parser.sv
// byte parser: header hunt, frame collection and raw axis assembly
module isfd_parser #(
    parameter int FRAME_LEN = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    output logic                 frm_valid,
    input  logic                 frm_ready,
    output isfd_pkg::frame_t     frm
);

    localparam logic [3:0] LAST_POS = 4'(FRAME_LEN - 1);

    isfd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    isfd_pkg::kind_t  kind_reg, kind_next;
    logic [isfd_pkg::NUM_DATA-1:0][7:0] bytes_reg, bytes_next;
    logic             frm_valid_reg, frm_valid_next;
    isfd_pkg::frame_t frm_reg, frm_next;
    logic             in_fire;
    logic             emit;

    assign s_tready  = !frm_valid_reg || frm_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        bytes_next = bytes_reg;
        emit       = 1'b0;
        if (in_fire) begin
            unique case (phase_reg)
                isfd_pkg::PHASE_HDR: begin
                    if (s_tdata >= isfd_pkg::TYPE_ACC && s_tdata <= isfd_pkg::TYPE_ANGLE) begin
                        kind_next  = isfd_pkg::kind_t'(2'(s_tdata - isfd_pkg::TYPE_ACC));
                        pos_next   = isfd_pkg::BODY_START;
                        phase_next = isfd_pkg::PHASE_BODY;
                    end else if (s_tdata != isfd_pkg::HDR_BYTE) begin
                        phase_next = isfd_pkg::PHASE_HUNT;
                        pos_next   = '0;
                    end
                end
                isfd_pkg::PHASE_BODY: begin
                    if (pos_reg >= isfd_pkg::BODY_START && pos_reg <= isfd_pkg::LAST_DATA) begin
                        bytes_next[3'(pos_reg - isfd_pkg::BODY_START)] = s_tdata;
                    end
                    // header bytes inside the body are plain data
                    if (pos_reg >= LAST_POS) begin
                        emit       = 1'b1;
                        phase_next = isfd_pkg::PHASE_HUNT;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                default: begin
                    if (s_tdata == isfd_pkg::HDR_BYTE) begin
                        phase_next = isfd_pkg::PHASE_HDR;
                        pos_next   = 4'd1;
                    end else begin
                        phase_next = isfd_pkg::PHASE_HUNT;
                        pos_next   = '0;
                    end
                end
            endcase
        end
    end

    // little-endian pairs, the byte arriving now included
    always_comb begin
        frm_next      = frm_reg;
        frm_valid_next = frm_valid_reg && !frm_ready;
        if (emit) begin
            frm_valid_next = 1'b1;
            frm_next.kind  = kind_reg;
            for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
                frm_next.raw[i] = {bytes_next[2*i+1], bytes_next[2*i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= isfd_pkg::PHASE_HUNT;
            pos_reg       <= '0;
            kind_reg      <= isfd_pkg::KIND_ACC;
            frm_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        frm_reg   <= frm_next;
    end

    a_hunt_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && phase_reg == isfd_pkg::PHASE_HUNT && s_tdata != isfd_pkg::HDR_BYTE
        |=> phase_reg == isfd_pkg::PHASE_HUNT)
        else $error("hunt left without a header byte");

    a_body_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == isfd_pkg::PHASE_BODY
        |-> pos_reg >= isfd_pkg::BODY_START && pos_reg <= LAST_POS)
        else $error("body position out of frame");

    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && phase_reg == isfd_pkg::PHASE_BODY && pos_reg == LAST_POS
        |=> frm_valid_reg && phase_reg == isfd_pkg::PHASE_HUNT)
        else $error("last frame byte did not produce a frame");

    a_frame_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_valid_reg && !frm_ready |=> frm_valid_reg && $stable(frm_reg))
        else $error("stalled frame changed");

endmodule

### src/isfd_scale.sv
// scaler: raw axis values to Q16 results, with the output register
module isfd_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 frm_valid,
    output logic                 frm_ready,
    input  isfd_pkg::frame_t     frm,
    input  logic [isfd_pkg::NUM_AXES-1:0][isfd_pkg::OFFS_W-1:0] rate_bias,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           m_tuser,
    output logic [87:0]          m_tdata
);

    logic                                           m_tvalid_reg, m_tvalid_next;
    isfd_pkg::kind_t                                kind_reg, kind_next;
    logic [isfd_pkg::NUM_AXES-1:0][isfd_pkg::VALUE_W-1:0] value_reg, value_next;

    function automatic logic signed [isfd_pkg::VALUE_W-1:0] scale_axis(
        input isfd_pkg::kind_t                  kind,
        input logic [isfd_pkg::RAW_W-1:0]       raw,
        input logic [isfd_pkg::OFFS_W-1:0]      off
    );
        logic signed [isfd_pkg::VALUE_W-1:0] r;
        logic signed [isfd_pkg::VALUE_W-1:0] o;
        logic signed [isfd_pkg::VALUE_W-1:0] res;
        r = isfd_pkg::VALUE_W'(signed'(raw));
        o = isfd_pkg::VALUE_W'(signed'(off));
        unique case (kind)
            isfd_pkg::KIND_ACC:  res = r * isfd_pkg::ACC_GAIN;
            isfd_pkg::KIND_RATE: res = -(r * isfd_pkg::RATE_GAIN) - o;
            default:             res = isfd_pkg::ANGLE_BIAS - r * isfd_pkg::ANGLE_GAIN;
        endcase
        return res;
    endfunction

    assign frm_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        kind_next     = kind_reg;
        value_next    = value_reg;
        if (frm_valid && frm_ready) begin
            m_tvalid_next = 1'b1;
            kind_next     = frm.kind;
            for (int i = 0; i < isfd_pkg::NUM_AXES; i++) begin
                value_next[i] = scale_axis(frm.kind, frm.raw[i], rate_bias[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {1'b0, value_reg};

endmodule

### src/imu_serial_frame_decoder_top.sv
// top level of the imu serial frame decoder
// accepts one byte per cycle unless an output stall holds ready; after the last frame byte
// a result passes the frame register, then the result register; frames stream back to back
// output stalls hold the result and back up into the byte input through ready
// aresetn is synchronous, active low: parser returns to header hunt, offsets clear
module imu_serial_frame_decoder_top #(
    parameter int FRAME_LEN = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // value_x[28:0], value_y[57:29], value_z[86:58], zero pad
    output logic [1:0]  m_tuser,    // frame_kind[1:0]
    input  logic        cfg_wr_en,
    input  logic [isfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [isfd_pkg::OFFS_W-1:0]     cfg_wr_data
);

    logic [isfd_pkg::NUM_AXES-1:0][isfd_pkg::OFFS_W-1:0] offset_reg;
    logic             frm_valid;
    logic             frm_ready;
    isfd_pkg::frame_t frm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                isfd_pkg::REG_RATE_BIAS_X: offset_reg[0] <= cfg_wr_data;
                isfd_pkg::REG_RATE_BIAS_Y: offset_reg[1] <= cfg_wr_data;
                isfd_pkg::REG_RATE_BIAS_Z: offset_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    isfd_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    isfd_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frm_valid   (frm_valid),
        .frm_ready   (frm_ready),
        .frm         (frm),
        .rate_bias   (offset_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

endmodule
